### rtl/core/dcc4_pkg.sv
// Shared constants, types and codes for the depthwise causal 4-tap convolution block.
`timescale 1ns / 1ps
`default_nettype none

package dcc4_pkg;

  // Sizing
  localparam int MAX_CHANNELS = 256;
  localparam int POOL_SLOTS   = 16;
  localparam int SAMPLE_BITS  = 16;

  localparam int TAPS = 4;
  localparam int HIST = 3;

  // Fixed field widths of one input item
  localparam int KIND_W = 2;
  localparam int CHAN_W = 8;
  localparam int SLOT_W = 4;
  localparam int SEL_W  = 3;
  localparam int STAT_W = 2;

  // Input tdata layout, lowest bits first
  localparam int OFF_CHAN  = 0;
  localparam int OFF_SRC   = OFF_CHAN + CHAN_W;
  localparam int OFF_DST   = OFF_SRC + SLOT_W;
  localparam int OFF_SEL   = OFF_DST + SLOT_W;
  localparam int OFF_VALUE = OFF_SEL + SEL_W;
  localparam int IN_BITS   = OFF_VALUE + SAMPLE_BITS;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  // Storage geometry
  localparam int HIST_ROWS = POOL_SLOTS * MAX_CHANNELS;
  localparam int ROW_W     = $clog2(HIST_ROWS);
  localparam int CHAN_AW   = $clog2(MAX_CHANNELS);
  localparam int POS_W     = 2;

  // Datapath widths: four products, scaled bias and rounding term
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W  = 2 * SAMPLE_BITS + 4;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int CIU_W      = 9;
  localparam int SIU_W      = 5;
  localparam int SHIFT_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_OUTPUTS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC_SHIFT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_IN_USE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE    = 3'd4;

  localparam logic [SHIFT_W-1:0] FRAC_SHIFT_RESET = 4'd13;
  localparam logic [CIU_W-1:0]   CHANNELS_RESET   = 9'd256;
  localparam logic [SIU_W-1:0]   SLOTS_RESET      = 5'd16;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COEF    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HIST_WR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_HIST_RD = 2'd3;

  localparam logic [SEL_W-1:0] SEL_BIAS     = 3'd4;
  localparam logic [SEL_W-1:0] SEL_HIST_MAX = 3'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic [ROW_W-1:0]              row_t;
  typedef logic [CHAN_AW-1:0]            chan_addr_t;
  typedef logic [POS_W-1:0]              pos_t;

  // Saturation bounds of the output
  localparam longint VAL_MAX_L = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam acc_t   VAL_MAX   = acc_t'(VAL_MAX_L);
  localparam acc_t   VAL_MIN   = acc_t'(-VAL_MAX_L - 1);

  // Operation decided by the front end
  typedef enum logic [2:0] {
    OP_ERROR,
    OP_SAMPLE,
    OP_TAP_WR,
    OP_BIAS_WR,
    OP_HIST_WR,
    OP_HIST_RD
  } op_t;

  typedef struct packed {
    op_t        op;
    chan_addr_t chan;
    row_t       src_row;
    row_t       dst_row;
    pos_t       pos;
    sample_t    value;
  } cmd_t;

  typedef struct packed {
    logic               bias_enable;
    logic               emit_outputs;
    logic [SHIFT_W-1:0] frac_shift;
    logic [CIU_W-1:0]   channels_in_use;
    logic [SIU_W-1:0]   slots_in_use;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/core/depthwise_causal_conv4_state_pool.sv
// Top level: configuration registers, front end, command queue and back end.
//
// Depthwise causal 4-tap convolution with a pool of 16 saved 3-sample histories per
// channel. A sample transfer computes w0*h0 + w1*h1 + w2*h2 + w3*x (plus the channel
// bias when enabled), rounds half up by frac_shift, saturates to 16 bits and writes the
// shifted history back to the destination slot; other kinds load taps or bias and write
// or read single history entries. Every input transfer yields exactly one result
// transfer. Sustained rate is one item per clock while m_tready holds: the back end does
// one history read and one history write per cycle at its memory stage, with the last
// write forwarded to the item read at the same edge, so back-to-back samples on the same
// channel and slot need no stall. With no back pressure, an item passes the queue, memory
// read, products, sum and output register on its way to the result. The four-entry queue
// keeps input accepted while a result waits on m_tready. Taps, bias and history memories
// are not cleared: an entry reads undefined until written. Configuration is taken on any
// cycle with cfg_write high and must only change while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module depthwise_causal_conv4_state_pool (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [dcc4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcc4_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: chan_index, src_slot, dst_slot, tap_select, sample_value, zero pad
  input  logic [dcc4_pkg::S_TDATA_W-1:0]  s_tdata,
  // s_tuser: kind
  input  logic [dcc4_pkg::KIND_W-1:0]     s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: result_value, zero pad
  output logic [dcc4_pkg::M_TDATA_W-1:0]  m_tdata,
  // m_tuser: status
  output logic [dcc4_pkg::STAT_W-1:0]     m_tuser
);
  import dcc4_pkg::*;

  cfg_t    cfg;
  logic    push;
  cmd_t    push_cmd;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  cmd_t    q_head;
  sample_t result_value;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bias_enable     <= 1'b0;
      cfg.emit_outputs    <= 1'b1;
      cfg.frac_shift      <= FRAC_SHIFT_RESET;
      cfg.channels_in_use <= CHANNELS_RESET;
      cfg.slots_in_use    <= SLOTS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BIAS_ENABLE:     cfg.bias_enable     <= cfg_data[0];
        CFG_EMIT_OUTPUTS:    cfg.emit_outputs    <= cfg_data[0];
        CFG_FRAC_SHIFT:      cfg.frac_shift      <= cfg_data[SHIFT_W-1:0];
        CFG_CHANNELS_IN_USE: cfg.channels_in_use <= cfg_data[CIU_W-1:0];
        CFG_SLOTS_IN_USE:    cfg.slots_in_use    <= cfg_data[SIU_W-1:0];
        default: ;
      endcase
    end
  end

  dcc4_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  dcc4_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  dcc4_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .result_value (result_value),
    .status       (m_tuser)
  );

  assign m_tdata = M_TDATA_W'($unsigned(result_value));

endmodule

`default_nettype wire

### rtl/core/dcc4_front.sv
// Front end: unpacks input transfers, checks ranges and decodes them into commands.
`timescale 1ns / 1ps
`default_nettype none

module dcc4_front (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata: chan_index, src_slot, dst_slot, tap_select, sample_value, zero pad
  input  logic [dcc4_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: kind
  input  logic [dcc4_pkg::KIND_W-1:0]    s_tuser,
  input  dcc4_pkg::cfg_t                 cfg,
  input  logic                           q_full,
  output logic                           push,
  output dcc4_pkg::cmd_t                 cmd
);
  import dcc4_pkg::*;

  logic [CHAN_W-1:0] chan;
  logic [SLOT_W-1:0] src;
  logic [SLOT_W-1:0] dst;
  logic [SEL_W-1:0]  sel;
  logic              chan_ok;
  logic              src_ok;
  logic              dst_ok;

  // Row of the history pool for a slot and channel
  function automatic row_t row_of(input logic [SLOT_W-1:0] slot, input logic [CHAN_W-1:0] ch);
    return ROW_W'(32'(slot) * MAX_CHANNELS + 32'(ch));
  endfunction

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    chan = s_tdata[OFF_CHAN +: CHAN_W];
    src  = s_tdata[OFF_SRC +: SLOT_W];
    dst  = s_tdata[OFF_DST +: SLOT_W];
    sel  = s_tdata[OFF_SEL +: SEL_W];

    chan_ok = ({1'b0, chan} < cfg.channels_in_use) && (32'(chan) < MAX_CHANNELS);
    src_ok  = (SIU_W'(src) < cfg.slots_in_use) && (32'(src) < POOL_SLOTS);
    dst_ok  = (SIU_W'(dst) < cfg.slots_in_use) && (32'(dst) < POOL_SLOTS);

    cmd.op      = OP_ERROR;
    cmd.chan    = CHAN_AW'(chan);
    cmd.src_row = row_of(src, chan);
    cmd.dst_row = row_of(dst, chan);
    cmd.pos     = sel[POS_W-1:0];
    cmd.value   = s_tdata[OFF_VALUE +: SAMPLE_BITS];

    // Decode; anything out of range stays an error and changes no state
    case (s_tuser)
      KIND_SAMPLE: begin
        if (chan_ok && src_ok && dst_ok) cmd.op = OP_SAMPLE;
      end
      KIND_COEF: begin
        if (chan_ok && sel <= SEL_BIAS) cmd.op = (sel == SEL_BIAS) ? OP_BIAS_WR : OP_TAP_WR;
      end
      KIND_HIST_WR: begin
        if (chan_ok && src_ok && sel <= SEL_HIST_MAX) cmd.op = OP_HIST_WR;
      end
      KIND_HIST_RD: begin
        if (chan_ok && src_ok && sel <= SEL_HIST_MAX) cmd.op = OP_HIST_RD;
      end
      default: cmd.op = OP_ERROR;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/dcc4_queue.sv
// Short command queue between the front end and the execution back end.
`timescale 1ns / 1ps
`default_nettype none

module dcc4_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dcc4_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output dcc4_pkg::cmd_t head,
  output logic           empty
);
  import dcc4_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic [QPTR_W:0]   count_next;

  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 1'b1;
    if (pop && !push) count_next = count - 1'b1;
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

`default_nettype wire

### rtl/core/dcc4_back.sv
// Back end: coefficient and history memories, forwarding, MAC pipeline and output register.
`timescale 1ns / 1ps
`default_nettype none

module dcc4_back (
  input  logic                          clk,
  input  logic                          rst,
  input  dcc4_pkg::cfg_t                cfg,
  input  logic                          q_empty,
  input  dcc4_pkg::cmd_t                q_head,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output dcc4_pkg::sample_t             result_value,
  output logic [dcc4_pkg::STAT_W-1:0]   status
);
  import dcc4_pkg::*;

  // Pipeline control: the whole pipe moves when the output register can take a result
  logic adv;
  logic m_fire;
  logic out_valid;

  // Memories and their registered read data
  sample_t hist_mem [HIST][HIST_ROWS];
  sample_t tap_mem  [TAPS][MAX_CHANNELS];
  sample_t bias_mem [MAX_CHANNELS];
  sample_t hist_rd  [HIST];
  sample_t tap_rd   [TAPS];
  sample_t bias_rd;

  // Memory stage
  logic    m_valid;
  cmd_t    m_cmd;
  sample_t eff_h   [HIST];
  sample_t eff_tap [TAPS];
  sample_t eff_bias;
  sample_t opnd    [TAPS];
  sample_t rd_sel;

  // Write strobes issued from the memory stage
  logic [HIST-1:0] hist_we;
  row_t            hist_wrow;
  sample_t         hist_wdata [HIST];
  logic [TAPS-1:0] tap_we;
  logic            bias_we;

  // Last write, kept to cover a read issued at the same edge
  logic [HIST-1:0] lw_hist_we;
  row_t            lw_hist_row;
  sample_t         lw_hist_data [HIST];
  logic [TAPS-1:0] lw_tap_we;
  logic            lw_bias_we;
  chan_addr_t      lw_chan;
  sample_t         lw_wval;

  // Product stage
  logic    p_valid;
  op_t     p_op;
  prod_t   p_prod [TAPS];
  sample_t p_bias;
  sample_t p_rd;

  // Sum stage
  logic    s_valid;
  op_t     s_op;
  acc_t    s_sum;
  sample_t s_rd;
  acc_t    sum;
  acc_t    bias_term;
  acc_t    round_term;
  acc_t    shifted;

  sample_t           out_value;
  logic [STAT_W-1:0] out_status;
  sample_t           out_value_next;
  logic [STAT_W-1:0] out_status_next;

  assign adv    = !out_valid || m_tready;
  assign q_pop  = adv && !q_empty;
  assign m_fire = adv && m_valid;

  assign m_tvalid     = out_valid;
  assign result_value = out_value;
  assign status       = out_status;

  // Forwarded operands of the item in the memory stage
  always_comb begin
    for (int h = 0; h < HIST; h++) begin
      eff_h[h] = (lw_hist_we[h] && lw_hist_row == m_cmd.src_row) ? lw_hist_data[h] : hist_rd[h];
    end
    for (int t = 0; t < TAPS; t++) begin
      eff_tap[t] = (lw_tap_we[t] && lw_chan == m_cmd.chan) ? lw_wval : tap_rd[t];
    end
    eff_bias = (lw_bias_we && lw_chan == m_cmd.chan) ? lw_wval : bias_rd;

    opnd[0] = eff_h[0];
    opnd[1] = eff_h[1];
    opnd[2] = eff_h[2];
    opnd[3] = m_cmd.value;

    case (m_cmd.pos)
      2'd0:    rd_sel = eff_h[0];
      2'd1:    rd_sel = eff_h[1];
      default: rd_sel = eff_h[2];
    endcase
  end

  // Write strobes: samples shift history into the destination row, other writes set one entry
  always_comb begin
    hist_we       = '0;
    hist_wrow     = m_cmd.dst_row;
    hist_wdata[0] = eff_h[1];
    hist_wdata[1] = eff_h[2];
    hist_wdata[2] = m_cmd.value;
    tap_we        = '0;
    bias_we       = 1'b0;
    if (m_fire) begin
      case (m_cmd.op)
        OP_SAMPLE: hist_we = '1;
        OP_HIST_WR: begin
          hist_we[m_cmd.pos] = 1'b1;
          hist_wrow          = m_cmd.src_row;
          for (int h = 0; h < HIST; h++) hist_wdata[h] = m_cmd.value;
        end
        OP_TAP_WR:  tap_we[m_cmd.pos] = 1'b1;
        OP_BIAS_WR: bias_we = 1'b1;
        default: ;
      endcase
    end
  end

  // Memory ports: read at the queue head on pop, write from the memory stage
  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int h = 0; h < HIST; h++) hist_rd[h] <= hist_mem[h][q_head.src_row];
      for (int t = 0; t < TAPS; t++) tap_rd[t] <= tap_mem[t][q_head.chan];
      bias_rd <= bias_mem[q_head.chan];
    end
    for (int h = 0; h < HIST; h++) begin
      if (hist_we[h]) hist_mem[h][hist_wrow] <= hist_wdata[h];
    end
    for (int t = 0; t < TAPS; t++) begin
      if (tap_we[t]) tap_mem[t][m_cmd.chan] <= m_cmd.value;
    end
    if (bias_we) bias_mem[m_cmd.chan] <= m_cmd.value;
  end

  // Last-write record, control part
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_hist_we <= '0;
      lw_tap_we  <= '0;
      lw_bias_we <= 1'b0;
    end else if (adv) begin
      lw_hist_we <= hist_we;
      lw_tap_we  <= tap_we;
      lw_bias_we <= bias_we;
    end
  end

  // Last-write record, data part
  always_ff @(posedge clk) begin
    if (adv) begin
      lw_hist_row <= hist_wrow;
      for (int h = 0; h < HIST; h++) lw_hist_data[h] <= hist_wdata[h];
      lw_chan <= m_cmd.chan;
      lw_wval <= m_cmd.value;
    end
  end

  // Sum of products, scaled bias and rounding term, and the final shift of the registered sum
  always_comb begin
    bias_term  = cfg.bias_enable ? (acc_t'(p_bias) <<< cfg.frac_shift) : '0;
    round_term = (cfg.frac_shift != '0) ? (acc_t'(1) <<< (cfg.frac_shift - 1'b1)) : '0;
    sum = acc_t'(p_prod[0]) + acc_t'(p_prod[1]) + acc_t'(p_prod[2]) + acc_t'(p_prod[3])
        + bias_term + round_term;
    shifted = s_sum >>> cfg.frac_shift;
  end

  // Saturation and result selection
  always_comb begin
    out_value_next  = '0;
    out_status_next = ST_OK;
    case (s_op)
      OP_SAMPLE: begin
        if (cfg.emit_outputs) begin
          if (shifted > VAL_MAX) begin
            out_value_next  = VAL_MAX[SAMPLE_BITS-1:0];
            out_status_next = ST_SAT;
          end else if (shifted < VAL_MIN) begin
            out_value_next  = VAL_MIN[SAMPLE_BITS-1:0];
            out_status_next = ST_SAT;
          end else begin
            out_value_next = shifted[SAMPLE_BITS-1:0];
          end
        end
      end
      OP_HIST_RD: out_value_next = s_rd;
      OP_ERROR:   out_status_next = ST_RANGE;
      default: ;
    endcase
  end

  // Valid bits of all stages
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      p_valid   <= 1'b0;
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      m_valid   <= q_pop;
      p_valid   <= m_valid;
      s_valid   <= p_valid;
      out_valid <= s_valid;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      m_cmd <= q_head;

      p_op <= m_cmd.op;
      for (int t = 0; t < TAPS; t++) p_prod[t] <= prod_t'(eff_tap[t]) * prod_t'(opnd[t]);
      p_bias <= eff_bias;
      p_rd   <= rd_sel;

      s_op  <= p_op;
      s_sum <= sum;
      s_rd  <= p_rd;

      out_value  <= out_value_next;
      out_status <= out_status_next;
    end
  end

endmodule

`default_nettype wire
